// ===== design/sbdb_pkg.sv =====
package sbdb_pkg;

	// field widths
	localparam int IN_W       = 24;
	localparam int DB_W       = 16;
	localparam int MAG_W      = 24;
	localparam int SUM_W      = 24;
	localparam int BIDX_W     = 9;
	localparam int BCW        = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// level datapath
	localparam int MUL_W      = 32;
	localparam int PW_W       = 48;
	localparam int REM_W      = 26;
	localparam int X_W        = 31;
	localparam int FRAC_W     = 16;
	localparam int EXP_W      = 5;
	localparam int L_W        = EXP_W + FRAC_W;
	localparam int D_W        = L_W + 1;
	localparam int CNT_W      = 5;
	localparam int SQRT_STEPS = MAG_W;
	localparam int LOG_STEPS  = FRAC_W;

	localparam logic signed [D_W-1:0]  LOG2_REF_Q16    = 22'sd372118;
	localparam logic [MUL_W-1:0]       DB_PER_LOG2_Q24 = 32'd101008905;
	localparam logic signed [DB_W-1:0] DB_MAX          = 16'sd32767;
	localparam logic signed [DB_W-1:0] DB_ZERO_MAG     = 16'sh8000;
	localparam logic [SUM_W-1:0]       BAND_FLOOR      = 24'd5;
	localparam logic [SUM_W-1:0]       SUM_MAX         = 24'hFFFFFF;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_USE_MAGNITUDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USE_EQUALIZER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT    = 2'd2;

	localparam logic [BCW-1:0] BAND_COUNT_RST = 10'd9;

	typedef struct packed {
		logic           use_magnitude;
		logic           use_equalizer;
		logic [BCW-1:0] band_count;
	} cfg_t;

	typedef struct packed {
		logic [MAG_W-1:0]       mag;
		logic signed [DB_W-1:0] db;
	} lvl_res_t;

	typedef struct packed {
		logic signed [DB_W-1:0] bin_db;
		logic                   band_valid;
		logic [BIDX_W-1:0]      band_index;
		logic [SUM_W-1:0]       band_sum;
		logic [MAG_W-1:0]       peak_magnitude;
		logic                   frame_last;
	} band_res_t;

endpackage

// ===== design/sbdb_mul.sv =====
module sbdb_mul import sbdb_pkg::*; (
	input  logic [MUL_W-1:0]   a,
	input  logic [MUL_W-1:0]   b,
	output logic [2*MUL_W-1:0] p
);

	assign p = a * b;

endmodule

// ===== design/sbdb_level.sv =====
module sbdb_level import sbdb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   ack,
	input  logic signed [IN_W-1:0] re,
	input  logic signed [IN_W-1:0] im,
	output logic                   done,
	output lvl_res_t               res
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PWR_RE,
		ST_PWR_IM,
		ST_SQRT,
		ST_NORM,
		ST_LOG,
		ST_SCALE,
		ST_ROUND,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [IN_W-1:0]        abs_re_q;
	logic [IN_W-1:0]        abs_im_q;
	logic [PW_W-1:0]        pw_q;
	logic [REM_W-1:0]       rem_q;
	logic [MAG_W-1:0]       root_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [EXP_W-1:0]       exp_q;
	logic [X_W-1:0]         x_q;
	logic [FRAC_W-1:0]      frac_q;
	logic                   neg_q;
	logic [PW_W-1:0]        prod_q;
	logic signed [DB_W-1:0] db_q;

	logic [MUL_W-1:0]       mul_a;
	logic [MUL_W-1:0]       mul_b;
	logic [2*MUL_W-1:0]     mul_p;

	logic [IN_W-1:0]        abs_re;
	logic [IN_W-1:0]        abs_im;
	logic [REM_W-1:0]       rem_n;
	logic [REM_W-1:0]       trial;
	logic                   sq_ge;
	logic [EXP_W-1:0]       msb;
	logic [X_W-1:0]         x_norm;
	logic [MUL_W-1:0]       sq;
	logic [L_W-1:0]         lg;
	logic signed [D_W-1:0]  d;
	logic [L_W-1:0]         abs_d;
	logic [DB_W:0]          v;
	logic signed [DB_W-1:0] v_sat;
	logic signed [DB_W-1:0] db_r;

	sbdb_mul u_mul (
		.a(mul_a),
		.b(mul_b),
		.p(mul_p)
	);

	assign abs_re = re[IN_W-1] ? IN_W'($unsigned(-re)) : IN_W'($unsigned(re));
	assign abs_im = im[IN_W-1] ? IN_W'($unsigned(-im)) : IN_W'($unsigned(im));

	// one root bit per step: bring down two radicand bits, try 4*root+1
	assign rem_n = {rem_q[REM_W-3:0], pw_q[PW_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign sq_ge = rem_n >= trial;

	always_comb begin
		msb = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (root_q[i]) begin
				msb = EXP_W'(i);
			end
		end
	end

	// Q30 mantissa in [1,2)
	assign x_norm = X_W'(root_q) << (EXP_W'(X_W - 1) - msb);

	assign sq = mul_p[X_W-1 +: MUL_W];

	assign lg    = {exp_q, frac_q};
	assign d     = $signed({1'b0, lg}) - LOG2_REF_Q16;
	assign abs_d = d[D_W-1] ? L_W'($unsigned(-d)) : L_W'($unsigned(d));

	// round half away from zero on the magnitude, then restore sign
	assign v     = {1'b0, prod_q[PW_W-1 -: DB_W]} + (DB_W+1)'(prod_q[MUL_W-1]);
	assign v_sat = (v > (DB_W+1)'($unsigned(DB_MAX))) ? DB_MAX : $signed(v[DB_W-1:0]);
	assign db_r  = neg_q ? -v_sat : v_sat;

	always_comb begin
		unique case (state_q)
			ST_PWR_RE: begin
				mul_a = MUL_W'(abs_re_q);
				mul_b = MUL_W'(abs_re_q);
			end
			ST_PWR_IM: begin
				mul_a = MUL_W'(abs_im_q);
				mul_b = MUL_W'(abs_im_q);
			end
			ST_LOG: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(x_q);
			end
			ST_SCALE: begin
				mul_a = MUL_W'(abs_d);
				mul_b = DB_PER_LOG2_Q24;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			abs_re_q <= '0;
			abs_im_q <= '0;
			pw_q     <= '0;
			rem_q    <= '0;
			root_q   <= '0;
			cnt_q    <= '0;
			exp_q    <= '0;
			x_q      <= '0;
			frac_q   <= '0;
			neg_q    <= 1'b0;
			prod_q   <= '0;
			db_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						abs_re_q <= abs_re;
						abs_im_q <= abs_im;
						state_q  <= ST_PWR_RE;
					end
				end
				ST_PWR_RE: begin
					pw_q    <= mul_p[PW_W-1:0];
					state_q <= ST_PWR_IM;
				end
				ST_PWR_IM: begin
					pw_q    <= pw_q + mul_p[PW_W-1:0];
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= CNT_W'(SQRT_STEPS - 1);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					rem_q  <= sq_ge ? rem_n - trial : rem_n;
					root_q <= {root_q[MAG_W-2:0], sq_ge};
					pw_q   <= pw_q << 2;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (root_q == '0) begin
						db_q    <= DB_ZERO_MAG;
						state_q <= ST_DONE;
					end else begin
						exp_q   <= msb;
						x_q     <= x_norm;
						frac_q  <= '0;
						cnt_q   <= CNT_W'(LOG_STEPS - 1);
						state_q <= ST_LOG;
					end
				end
				ST_LOG: begin
					// squaring doubles log2; overflow past 2.0 yields the next bit
					frac_q <= {frac_q[FRAC_W-2:0], sq[MUL_W-1]};
					x_q    <= sq[MUL_W-1] ? sq[MUL_W-1:1] : sq[X_W-1:0];
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					prod_q  <= mul_p[PW_W-1:0];
					neg_q   <= d[D_W-1];
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					db_q    <= db_r;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done    = (state_q == ST_DONE);
	assign res.mag = root_q;
	assign res.db  = db_q;

endmodule

// ===== design/sbdb_band.sv =====
module sbdb_band import sbdb_pkg::*; #(
	parameter int FRAME_BINS = 512
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     start,
	input  logic     commit,
	input  logic     first,
	input  lvl_res_t lvl,
	output logic     div_done,
	output band_res_t res
);

	localparam int BPW  = $clog2(FRAME_BINS);
	localparam int QW   = $clog2(FRAME_BINS + 1);
	localparam int PCW  = QW + 1;
	localparam int DCW  = $clog2(QW + 1);
	localparam int SW   = SUM_W + 2;
	localparam logic [QW-1:0]  FRAME_NUM = QW'(FRAME_BINS);
	localparam logic [BPW-1:0] LAST_POS  = BPW'(FRAME_BINS - 1);
	localparam logic signed [SW-1:0] SUM_LO = SW'(BAND_FLOOR);
	localparam logic signed [SW-1:0] SUM_HI = SW'(SUM_MAX);

	logic [BPW-1:0]   bin_pos_q;
	logic [BPW-1:0]   band_pos_q;
	logic [BCW-1:0]   band_num_q;
	logic [SUM_W-1:0] acc_q;
	logic [MAG_W-1:0] peak_q;

	logic [QW-1:0]    num_q;
	logic [BCW-1:0]   drem_q;
	logic [QW-1:0]    per_q;
	logic [DCW-1:0]   dcnt_q;

	logic [BCW-1:0]   bc_eff;
	logic [BCW:0]     drem_n;
	logic             d_ge;

	logic [BPW-1:0]   bp;
	logic [BPW-1:0]   bbp;
	logic [BCW-1:0]   bn;
	logic [SUM_W-1:0] acc;
	logic [MAG_W-1:0] pk;
	logic             mag_en;
	logic signed [DB_W-1:0] db;
	logic signed [SW-1:0]   s;
	logic [SUM_W-1:0] sum_c;
	logic             in_band;
	logic             band_end;
	logic             last;

	logic [BPW-1:0]   bp_n;
	logic [BPW-1:0]   bbp_n;
	logic [BCW-1:0]   bn_n;
	logic [SUM_W-1:0] acc_n;
	logic [MAG_W-1:0] pk_n;

	always_comb begin
		if (cfg.band_count == '0) begin
			bc_eff = BCW'(1);
		end else if (32'(cfg.band_count) > 32'(FRAME_BINS)) begin
			bc_eff = BCW'(FRAME_BINS);
		end else begin
			bc_eff = cfg.band_count;
		end
	end

	// bins per band: restoring division of the frame length, one quotient bit a cycle
	assign drem_n = {drem_q, num_q[QW-1]};
	assign d_ge   = drem_n >= {1'b0, bc_eff};

	assign div_done = (dcnt_q == '0);

	assign bp     = first ? '0 : bin_pos_q;
	assign bbp    = first ? '0 : band_pos_q;
	assign bn     = first ? '0 : band_num_q;
	assign acc    = first ? '0 : acc_q;
	assign pk     = first ? '0 : peak_q;
	assign mag_en = cfg.use_magnitude | cfg.use_equalizer;
	assign db     = mag_en ? lvl.db : '0;

	assign s = $signed({2'b00, acc}) + SW'(db);

	always_comb begin
		if (s < SUM_LO) begin
			sum_c = BAND_FLOOR;
		end else if (s > SUM_HI) begin
			sum_c = SUM_MAX;
		end else begin
			sum_c = s[SUM_W-1:0];
		end
	end

	assign in_band  = cfg.use_equalizer && (bn < bc_eff);
	assign band_end = (PCW'(bbp) + PCW'(1)) >= PCW'(per_q);
	assign last     = bp >= LAST_POS;
	assign pk_n     = (mag_en && (lvl.mag > pk)) ? lvl.mag : pk;

	always_comb begin
		bbp_n = bbp;
		bn_n  = bn;
		acc_n = acc;
		res.bin_db         = db;
		res.peak_magnitude = pk_n;
		res.frame_last     = last;
		res.band_valid = 1'b0;
		res.band_index = '0;
		res.band_sum   = '0;
		if (in_band) begin
			if (band_end) begin
				res.band_valid = 1'b1;
				res.band_index = bn[BIDX_W-1:0];
				res.band_sum   = sum_c;
				acc_n = '0;
				bbp_n = '0;
				bn_n  = bn + 1'b1;
			end else begin
				acc_n = sum_c;
				bbp_n = bbp + 1'b1;
			end
		end
		bp_n = bp + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_pos_q  <= '0;
			band_pos_q <= '0;
			band_num_q <= '0;
			acc_q      <= '0;
			peak_q     <= '0;
			num_q      <= '0;
			drem_q     <= '0;
			per_q      <= '0;
			dcnt_q     <= '0;
		end else begin
			if (start) begin
				num_q  <= FRAME_NUM;
				drem_q <= '0;
				per_q  <= '0;
				dcnt_q <= DCW'(QW);
			end else if (dcnt_q != '0) begin
				drem_q <= d_ge ? BCW'(drem_n - {1'b0, bc_eff}) : BCW'(drem_n);
				per_q  <= {per_q[QW-2:0], d_ge};
				num_q  <= num_q << 1;
				dcnt_q <= dcnt_q - 1'b1;
			end
			if (commit) begin
				if (last) begin
					bin_pos_q  <= '0;
					band_pos_q <= '0;
					band_num_q <= '0;
					acc_q      <= '0;
					peak_q     <= '0;
				end else begin
					bin_pos_q  <= bp_n;
					band_pos_q <= bbp_n;
					band_num_q <= bn_n;
					acc_q      <= acc_n;
					peak_q     <= pk_n;
				end
			end
		end
	end

endmodule

// ===== design/spectrum_bin_db_band_grouper_top.sv =====
// Spectrum bin level and band grouper. Takes one complex FFT bin (signed Q15.8) per
// transfer and returns one result per bin: the level 20*log10(|X|/0.2) in signed Q8.8
// (-32768 for a zero magnitude, 0 with both enables off), the running frame peak of the
// linear magnitude, a frame_last flag on bin FRAME_BINS, and, with the equalizer enabled,
// the floor-clamped dB sum of each band at the band's last bin. A bin passes through two
// power steps on one shared 32x32 multiplier, a 24-step bit-serial square root, then
// (for a nonzero magnitude) 16 log2 squarings and the dB scaling on the same
// multiplier, all under one sequencer; the next bin is taken the cycle after its
// result moves into the output register. Results sit in that output register, so a
// new bin is taken while one waits.
// Configuration writes take effect at once and belong in idle periods.
module spectrum_bin_db_band_grouper_top import sbdb_pkg::*; #(
	parameter int FRAME_BINS = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [IN_W-1:0]       bin_real,
	input  logic signed [IN_W-1:0]       bin_imag,
	input  logic                         first_bin,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DB_W-1:0]       bin_db,
	output logic                         band_valid,
	output logic [BIDX_W-1:0]            band_index,
	output logic [SUM_W-1:0]             band_sum,
	output logic [MAG_W-1:0]             peak_magnitude,
	output logic                         frame_last
);

	cfg_t      cfg_q;
	logic      busy_q;
	logic      first_q;
	logic      out_valid_q;
	band_res_t out_q;

	logic      accept;
	logic      finish;
	logic      lvl_done;
	logic      div_done;
	lvl_res_t  lvl_res;
	band_res_t band_res;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	// result leaves only when the output register is free or draining this cycle
	assign finish   = busy_q && lvl_done && div_done && (!out_valid_q || out_ready);

	sbdb_level u_level (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.ack   (finish),
		.re    (bin_real),
		.im    (bin_imag),
		.done  (lvl_done),
		.res   (lvl_res)
	);

	sbdb_band #(
		.FRAME_BINS(FRAME_BINS)
	) u_band (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.start   (accept),
		.commit  (finish),
		.first   (first_q),
		.lvl     (lvl_res),
		.div_done(div_done),
		.res     (band_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_magnitude <= 1'b1;
			cfg_q.use_equalizer <= 1'b1;
			cfg_q.band_count    <= BAND_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_USE_MAGNITUDE: cfg_q.use_magnitude <= cfg_data[0];
				REG_USE_EQUALIZER: cfg_q.use_equalizer <= cfg_data[0];
				REG_BAND_COUNT:    cfg_q.band_count    <= cfg_data[BCW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q  <= 1'b1;
				first_q <= first_bin;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q <= band_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign bin_db         = out_q.bin_db;
	assign band_valid     = out_q.band_valid;
	assign band_index     = out_q.band_index;
	assign band_sum       = out_q.band_sum;
	assign peak_magnitude = out_q.peak_magnitude;
	assign frame_last     = out_q.frame_last;

endmodule
